@@ hdl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH   = 32;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int PRIO_W  = 16;
	localparam int TOTAL_W = 6;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} stat_t;

	// Broadcast to every cell in the cycle a transfer is taken.
	typedef struct packed {
		logic                     enq;
		logic                     deq;
		logic signed [PRIO_W-1:0] prio;
	} cell_ctl_t;

endpackage

@@ hdl/spq_cell.sv @@
// One slot of the sorted array: holds a priority and trades it with its neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic                     occ,
	input  logic                     prev_keep,
	input  logic signed [PRIO_W-1:0] prev_val,
	input  logic signed [PRIO_W-1:0] next_val,
	output logic                     keep,
	output logic signed [PRIO_W-1:0] val
);

	logic signed [PRIO_W-1:0] val_q;

	// Stays put on enqueue when it holds an entry ranked ahead of the newcomer.
	assign keep = occ && (val_q >= ctl.prio);
	assign val  = val_q;

	always_ff @(posedge clk) begin
		if (ctl.enq && !keep) begin
			// first non-kept slot takes the new entry, the rest shift back
			val_q <= prev_keep ? ctl.prio : prev_val;
		end else if (ctl.deq) begin
			val_q <= next_val;
		end
	end

endmodule

@@ hdl/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue: a row of spq_cell slots plus count and result registers.
// Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps

// Channel   Handshake           Payload
// command   start / busy        command, priority_req
// result    done (strobe)       front_priority, status, entry_total
//
// One transfer per cycle; the result strobe is registered and comes in the cycle after its command.
// Every slot compares its entry with the new priority in parallel, so an
// enqueue or dequeue never has to wait; busy stays low.
// arst_n clears the entry count and the result strobe; slot contents stay unknown
// until written and are never read beyond the count.
// The receiver cannot stall: a result lasts one cycle only.

module sorted_priority_queue_core import spq_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      command,
	input  logic signed [PRIO_W-1:0]  priority_req,
	output logic                      done,
	output logic signed [PRIO_W-1:0]  front_priority,
	output logic [1:0]                status,
	output logic [TOTAL_W-1:0]        entry_total
);

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_nxt;
	logic                     done_q;
	logic signed [PRIO_W-1:0] front_q;
	stat_t                    stat_q;
	logic [TOTAL_W-1:0]       total_q;

	logic                     take;
	logic                     full;
	logic                     empty;
	stat_t                    stat_nxt;
	cell_ctl_t                ctl;

	logic                     keep [DEPTH];
	logic signed [PRIO_W-1:0] val  [DEPTH];

	// Every cell decides in the same cycle, so no command ever has to wait.
	assign busy  = 1'b0;
	assign take  = start && !busy;
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		ctl.enq   = 1'b0;
		ctl.deq   = 1'b0;
		ctl.prio  = priority_req;
		count_nxt = count_q;
		stat_nxt  = STAT_OK;
		if (take) begin
			unique case (cmd_t'(command))
				CMD_ENQ: begin
					if (full) begin
						stat_nxt = STAT_FULL;
					end else begin
						ctl.enq   = 1'b1;
						count_nxt = count_q + CNT_W'(1);
					end
				end
				CMD_DEQ: begin
					if (empty) begin
						stat_nxt = STAT_EMPTY;
					end else begin
						ctl.deq   = 1'b1;
						count_nxt = count_q - CNT_W'(1);
					end
				end
				default: begin
					stat_nxt = STAT_OK;
				end
			endcase
		end
	end

	// The row of slots, front at index 0.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     occ;
		logic                     p_keep;
		logic signed [PRIO_W-1:0] p_val;
		logic signed [PRIO_W-1:0] n_val;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign p_keep = 1'b1;
			assign p_val  = '0;
		end else begin : g_body
			assign p_keep = keep[i-1];
			assign p_val  = val[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_val = '0;
		end else begin : g_inner
			assign n_val = val[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (occ),
			.prev_keep (p_keep),
			.prev_val  (p_val),
			.next_val  (n_val),
			.keep      (keep[i]),
			.val       (val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= take;
		end
	end

	// Result payload; only meaningful while done is high.
	always_ff @(posedge clk) begin
		if (take) begin
			front_q <= ctl.deq ? val[0] : '0;
			stat_q  <= stat_nxt;
			total_q <= TOTAL_W'(count_nxt);
		end
	end

	assign done           = done_q;
	assign front_priority = front_q;
	assign status         = stat_q;
	assign entry_total    = total_q;

endmodule

@@ hdl/spq_checker.sv @@
// Port-level checks for sorted_priority_queue_core, attached by bind.
// Depends on spq_pkg and the top level's port list.
`timescale 1ns / 1ps

module spq_checker import spq_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     command,
	input logic signed [PRIO_W-1:0] priority_req,
	input logic                     done,
	input logic signed [PRIO_W-1:0] front_priority,
	input logic [1:0]               status,
	input logic [TOTAL_W-1:0]       entry_total
);

	a_done_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("taken command gave no result");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without a command");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_OK) |-> (front_priority == '0))
		else $error("refused command returned a priority");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_EMPTY) |-> (entry_total == '0))
		else $error("empty refusal with nonzero count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_FULL) |-> (entry_total == TOTAL_W'(DEPTH)))
		else $error("full refusal with wrong count");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench for sorted_priority_queue_core: directed and random enqueue/dequeue
// traffic, checked against a behavioral sorted-list model. Depends on spq_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
	import spq_pkg::*;

	// One expected result transfer
	typedef struct {
		logic signed [PRIO_W-1:0] front;
		stat_t                    stat;
		logic [TOTAL_W-1:0]       total;
	} outcome_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     command;
	logic signed [PRIO_W-1:0] priority_req;
	logic                     done;
	logic signed [PRIO_W-1:0] front_priority;
	logic [1:0]               status;
	logic [TOTAL_W-1:0]       entry_total;

	// Model of the queue contents, front at index 0
	logic signed [PRIO_W-1:0] model_entries[$];
	// Results still owed by the core, oldest first
	outcome_t                 awaited_outcomes[$];

	int failures;
	int sender_idle_pct;
	int enq_sent, deq_sent, full_hits, empty_hits, deepest;

	sorted_priority_queue_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.priority_req   (priority_req),
		.done           (done),
		.front_priority (front_priority),
		.status         (status),
		.entry_total    (entry_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Applies one command to the model and returns the result the core should give.
	// A new entry goes behind every entry of greater or equal priority.
	function automatic outcome_t apply_queue_op(input cmd_t cmd,
			input logic signed [PRIO_W-1:0] prio);
		outcome_t o;
		int       pos;
		o.front = '0;
		o.stat  = STAT_OK;
		if (cmd == CMD_ENQ) begin
			enq_sent++;
			if (model_entries.size() >= DEPTH) begin
				o.stat = STAT_FULL;
				full_hits++;
			end else begin
				pos = 0;
				while (pos < model_entries.size() && model_entries[pos] >= prio)
					pos++;
				model_entries.insert(pos, prio);
			end
		end else begin
			deq_sent++;
			if (model_entries.size() == 0) begin
				o.stat = STAT_EMPTY;
				empty_hits++;
			end else begin
				o.front = model_entries.pop_front();
			end
		end
		if (model_entries.size() > deepest)
			deepest = model_entries.size();
		o.total = TOTAL_W'(model_entries.size());
		return o;
	endfunction

	// Sends one command transfer. Called right after a rising edge; leaves start high so
	// back-to-back transfers never see start dropped and raised in one step.
	task automatic send_item(input cmd_t cmd, input logic signed [PRIO_W-1:0] prio);
		bit taken;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start        <= 1'b1;
		command      <= cmd;
		priority_req <= prio;
		// busy is stable by the falling edge; the transfer happens at the next rising edge
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		awaited_outcomes.push_back(apply_queue_op(cmd, prio));
	endtask

	// Mix of full-range values, a narrow band that makes ties, and the extremes
	function automatic logic signed [PRIO_W-1:0] pick_priority();
		case ($urandom_range(3))
			0: return PRIO_W'($urandom_range(8)) - PRIO_W'(4);
			1: case ($urandom_range(3))
				0: return 16'sh8000;
				1: return 16'sh7fff;
				2: return 16'sh8001;
				default: return 16'sh7ffe;
			endcase
			default: return PRIO_W'($urandom);
		endcase
	endfunction

	// Result side: the core cannot be stalled, so each strobe is taken as it comes.
	// Sampled at the falling edge, where outputs are settled.
	always @(negedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (awaited_outcomes.size() == 0) begin
				$error({"result transfer with nothing outstanding: ",
					"front_priority=%0d status=%0d entry_total=%0d"},
					front_priority, status, entry_total);
				failures++;
			end else begin
				want = awaited_outcomes.pop_front();
				if (front_priority !== want.front) begin
					$error("front_priority: expected %0d, got %0d", want.front, front_priority);
					failures++;
				end
				if (status !== want.stat) begin
					$error("status: expected %0d, got %0d", want.stat, status);
					failures++;
				end
				if (entry_total !== want.total) begin
					$error("entry_total: expected %0d, got %0d", want.total, entry_total);
					failures++;
				end
			end
		end
	end

	// Dequeue on an empty queue, the priority extremes, ties and zero, then drain past empty
	task automatic test_directed();
		send_item(CMD_DEQ, 16'sh1234);
		send_item(CMD_ENQ, 16'sh7fff);
		send_item(CMD_ENQ, 16'sh8000);
		send_item(CMD_ENQ, 16'sh0000);
		send_item(CMD_ENQ, 16'sh0000);
		send_item(CMD_ENQ, -16'sd1);
		send_item(CMD_ENQ, 16'sd1);
		send_item(CMD_ENQ, 16'sh7fff);
		send_item(CMD_ENQ, 16'sh8000);
		repeat (9)
			send_item(CMD_DEQ, 16'shffff);
		send_item(CMD_DEQ, 16'sh0000);
	endtask

	// Runs of enqueue-heavy, balanced and dequeue-heavy traffic so the queue keeps
	// swinging between full and empty.
	task automatic test_random_mix(input int items, input int idle_pct);
		int sent;
		int run_len;
		int enq_pct;
		sender_idle_pct = idle_pct;
		sent = 0;
		while (sent < items) begin
			run_len = $urandom_range(20, 60);
			case ($urandom_range(2))
				0: enq_pct = 90;
				1: enq_pct = 50;
				default: enq_pct = 10;
			endcase
			for (int k = 0; k < run_len && sent < items; k++) begin
				if ($urandom_range(99) < enq_pct)
					send_item(CMD_ENQ, pick_priority());
				else
					send_item(CMD_DEQ, PRIO_W'($urandom));
				sent++;
			end
		end
	endtask

	// Fill to the top, overflow twice, then empty it completely
	task automatic test_fill_overflow();
		sender_idle_pct = 0;
		while (model_entries.size() < DEPTH)
			send_item(CMD_ENQ, pick_priority());
		send_item(CMD_ENQ, 16'sh7fff);
		send_item(CMD_ENQ, 16'sh8000);
		while (model_entries.size() > 0)
			send_item(CMD_DEQ, PRIO_W'($urandom));
		send_item(CMD_DEQ, 16'sh7fff);
	endtask

	initial begin
		int waited;
		failures        = 0;
		sender_idle_pct = 0;
		enq_sent        = 0;
		deq_sent        = 0;
		full_hits       = 0;
		empty_hits      = 0;
		deepest         = 0;
		arst_n          = 1'b0;
		start           = 1'b0;
		command         = CMD_ENQ;
		priority_req    = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 35;
		test_directed();
		test_random_mix(120, 35);
		test_random_mix(120, 87);
		test_random_mix(110, 0);
		test_fill_overflow();
		start <= 1'b0;

		// Results land in the cycle after their command; allow ample slack
		waited = 0;
		while (awaited_outcomes.size() != 0 && waited < 50) begin
			@(posedge clk);
			waited++;
		end
		if (awaited_outcomes.size() != 0) begin
			$error("%0d result transfers never arrived", awaited_outcomes.size());
			failures++;
		end
		repeat (4) @(posedge clk);

		$display("Covered %0d enqueues (%0d refused as full)", enq_sent, full_hits);
		$display("and %0d dequeues (%0d refused as empty)", deq_sent, empty_hits);
		$display("Deepest queue held %0d entries; %0d check failures", deepest, failures);
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
